// ===== src/selective_repeat_arq_endpoint_macros.svh =====
// Assertion macros for the selective-repeat ARQ endpoint
`ifndef SELECTIVE_REPEAT_ARQ_ENDPOINT_MACROS_SVH
`define SELECTIVE_REPEAT_ARQ_ENDPOINT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRA_ASSERT(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sra assertion failed");
`define SRA_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sra assertion failed");
`else
`define SRA_ASSERT(name, cond)
`define SRA_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ===== src/sra_pkg.sv =====
// Shared types, codes and helpers for the selective-repeat ARQ endpoint
`timescale 1ns / 1ps
package sra_pkg;
    localparam int SEQ_W   = 3;
    localparam int SLOT_W  = 2;
    localparam int DATA_W  = 32;
    localparam int BUF_CNT = 4;
    localparam int CNT_W   = 3;

    localparam logic [SEQ_W-1:0] SEQ_MAX   = 3'd7;
    localparam logic [SEQ_W-1:0] WIN_RESET = 3'(BUF_CNT);

    localparam logic [2:0] ACT_PKT   = 3'd0;
    localparam logic [2:0] ACT_FRAME = 3'd1;
    localparam logic [2:0] ACT_CKSUM = 3'd2;
    localparam logic [2:0] ACT_DTMO  = 3'd3;
    localparam logic [2:0] ACT_ATMO  = 3'd4;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NAK  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_SEND      = 3'd0,
        OP_DELIVER   = 3'd1,
        OP_START     = 3'd2,
        OP_STOP      = 3'd3,
        OP_START_ACK = 3'd4,
        OP_STOP_ACK  = 3'd5,
        OP_DONE      = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RX_DATA, S_RX_STORE, S_DELIVER, S_DELIV_ACK,
        S_NAK_CHK, S_ACK_LOOP, S_TX_DATA, S_TX_NAK, S_TX_ACK, S_TX_START,
        S_TX_STOP_ACK, S_DONE
    } t_state;

    typedef struct packed {
        logic  load_in;
        logic  emit;
        t_op   op;
        t_kind kind;
        logic  push;
        logic  nr_expired;
        logic  nr_want;
        logic  clr_nak;
        logic  store;
        logic  deliver;
        logic  ack_step;
        logic  clr_guard;
    } t_cmd;

    typedef struct packed {
        logic [2:0] act;
        logic [1:0] kind;
        logic       full;
        logic       nak_allowed;
        logic       seq_ne_exp;
        logic       store_ok;
        logic       deliver_ok;
        logic       ackloop_ok;
        logic       nak_ok;
        logic       slot_free;
    } t_status;

    // b lies in the circular window [a, c)
    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction
endpackage

// ===== src/selective_repeat_arq_endpoint.sv =====
// The event is latched on the input transfer and decoded in a dispatch state;
// each result item is then written to the result register, and data and NAK
// frames add decision steps between their results.
// One event at a time: the block is ready again the cycle after the done item;
// a stalled result register holds the sequencer until the item is taken.
// Reset (synchronous, active low) restores windows, counters, no-NAK flag and marks.
`timescale 1ns / 1ps
`include "selective_repeat_arq_endpoint_macros.svh"
module selective_repeat_arq_endpoint (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_action,
    input  logic [1:0]                  i_rx_kind,
    input  logic [sra_pkg::SEQ_W-1:0]   i_rx_seq,
    input  logic [sra_pkg::SEQ_W-1:0]   i_rx_ack,
    input  logic [sra_pkg::DATA_W-1:0]  i_payload,
    input  logic [sra_pkg::SEQ_W-1:0]   i_expired_seq,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_op,
    output logic [1:0]                  o_tx_kind,
    output logic [sra_pkg::SEQ_W-1:0]   o_tx_seq,
    output logic [sra_pkg::SEQ_W-1:0]   o_tx_ack,
    output logic [sra_pkg::DATA_W-1:0]  o_data_word,
    output logic [sra_pkg::SLOT_W-1:0]  o_timer_slot,
    output logic                        o_upper_enable,
    output logic                        o_last
);
    sra_pkg::t_cmd    w_cmd;
    sra_pkg::t_status w_st;

    sra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    sra_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_action       (i_action),
        .i_rx_kind      (i_rx_kind),
        .i_rx_seq       (i_rx_seq),
        .i_rx_ack       (i_rx_ack),
        .i_payload      (i_payload),
        .i_expired_seq  (i_expired_seq),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_op           (o_op),
        .o_tx_kind      (o_tx_kind),
        .o_tx_seq       (o_tx_seq),
        .o_tx_ack       (o_tx_ack),
        .o_data_word    (o_data_word),
        .o_timer_slot   (o_timer_slot),
        .o_upper_enable (o_upper_enable),
        .o_last         (o_last)
    );

    `SRA_ASSERT(a_last_is_done, !o_out_valid || (o_last == (o_op == sra_pkg::OP_DONE)))
    `SRA_ASSERT(a_enable_only_done, !o_out_valid || o_last || !o_upper_enable)
    `SRA_ASSERT_NEXT(a_busy_after_transfer, i_in_valid && o_in_ready, !o_in_ready)
endmodule

// ===== src/sra_ctrl.sv =====
// Event sequencer for the selective-repeat ARQ endpoint
`timescale 1ns / 1ps
module sra_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sra_pkg::t_status i_st,
    output sra_pkg::t_cmd    o_cmd
);
    sra_pkg::t_state r_state, n_state, r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sra_pkg::S_IDLE;
            r_ret   <= sra_pkg::S_DONE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            sra_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sra_pkg::S_DISPATCH;
            end
            sra_pkg::S_DISPATCH: begin
                n_ret   = sra_pkg::S_DONE;
                n_state = sra_pkg::S_DONE;
                case (i_st.act)
                    sra_pkg::ACT_PKT: begin
                        if (!i_st.full) n_state = sra_pkg::S_TX_DATA;
                    end
                    sra_pkg::ACT_FRAME: begin
                        if (i_st.kind == sra_pkg::KIND_DATA) n_state = sra_pkg::S_RX_DATA;
                        else if (i_st.kind == sra_pkg::KIND_NAK) n_state = sra_pkg::S_NAK_CHK;
                        else n_state = sra_pkg::S_ACK_LOOP;
                    end
                    sra_pkg::ACT_CKSUM: begin
                        if (i_st.nak_allowed) n_state = sra_pkg::S_TX_NAK;
                    end
                    sra_pkg::ACT_DTMO: n_state = sra_pkg::S_TX_DATA;
                    sra_pkg::ACT_ATMO: n_state = sra_pkg::S_TX_ACK;
                    default: n_state = sra_pkg::S_DONE;
                endcase
            end
            sra_pkg::S_RX_DATA: begin
                if (i_st.seq_ne_exp && i_st.nak_allowed) begin
                    n_state = sra_pkg::S_TX_NAK;
                    n_ret   = sra_pkg::S_RX_STORE;
                end else if (i_st.slot_free) begin
                    n_state = sra_pkg::S_RX_STORE;
                end
            end
            sra_pkg::S_RX_STORE: begin
                n_state = i_st.store_ok ? sra_pkg::S_DELIVER : sra_pkg::S_ACK_LOOP;
            end
            sra_pkg::S_DELIVER: begin
                if (!i_st.deliver_ok) n_state = sra_pkg::S_ACK_LOOP;
                else if (i_st.slot_free) n_state = sra_pkg::S_DELIV_ACK;
            end
            sra_pkg::S_DELIV_ACK: begin
                if (i_st.slot_free) n_state = sra_pkg::S_DELIVER;
            end
            sra_pkg::S_NAK_CHK: begin
                if (i_st.nak_ok) begin
                    n_state = sra_pkg::S_TX_DATA;
                    n_ret   = sra_pkg::S_ACK_LOOP;
                end else begin
                    n_state = sra_pkg::S_ACK_LOOP;
                end
            end
            sra_pkg::S_ACK_LOOP: begin
                if (!i_st.ackloop_ok) n_state = sra_pkg::S_DONE;
            end
            sra_pkg::S_TX_DATA: begin
                if (i_st.slot_free) n_state = sra_pkg::S_TX_START;
            end
            sra_pkg::S_TX_START, sra_pkg::S_TX_NAK, sra_pkg::S_TX_ACK: begin
                if (i_st.slot_free) n_state = sra_pkg::S_TX_STOP_ACK;
            end
            sra_pkg::S_TX_STOP_ACK: begin
                if (i_st.slot_free) n_state = r_ret;
            end
            sra_pkg::S_DONE: begin
                if (i_st.slot_free) n_state = sra_pkg::S_IDLE;
            end
            default: n_state = sra_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = sra_pkg::OP_DONE;
        o_cmd.kind = sra_pkg::KIND_DATA;
        o_in_ready = 1'b0;
        case (r_state)
            sra_pkg::S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.load_in = i_in_valid && i_rst_n;
            end
            sra_pkg::S_DISPATCH: begin
                o_cmd.clr_guard  = 1'b1;
                o_cmd.push       = (i_st.act == sra_pkg::ACT_PKT) && !i_st.full;
                o_cmd.nr_expired = (i_st.act == sra_pkg::ACT_DTMO);
            end
            sra_pkg::S_RX_DATA: begin
                if (!(i_st.seq_ne_exp && i_st.nak_allowed)) begin
                    o_cmd.emit = i_st.slot_free;
                    o_cmd.op   = sra_pkg::OP_START_ACK;
                end
            end
            sra_pkg::S_RX_STORE: begin
                o_cmd.store     = i_st.store_ok;
                o_cmd.clr_guard = 1'b1;
            end
            sra_pkg::S_DELIVER: begin
                if (i_st.deliver_ok) begin
                    o_cmd.emit    = i_st.slot_free;
                    o_cmd.deliver = i_st.slot_free;
                    o_cmd.op      = sra_pkg::OP_DELIVER;
                end else begin
                    o_cmd.clr_guard = 1'b1;
                end
            end
            sra_pkg::S_DELIV_ACK: begin
                o_cmd.emit = i_st.slot_free;
                o_cmd.op   = sra_pkg::OP_START_ACK;
            end
            sra_pkg::S_NAK_CHK: begin
                o_cmd.nr_want = i_st.nak_ok;
            end
            sra_pkg::S_ACK_LOOP: begin
                if (i_st.ackloop_ok) begin
                    o_cmd.emit     = i_st.slot_free;
                    o_cmd.ack_step = i_st.slot_free;
                    o_cmd.op       = sra_pkg::OP_STOP;
                end
            end
            sra_pkg::S_TX_DATA: begin
                o_cmd.emit = i_st.slot_free;
                o_cmd.op   = sra_pkg::OP_SEND;
                o_cmd.kind = sra_pkg::KIND_DATA;
            end
            sra_pkg::S_TX_NAK: begin
                o_cmd.emit    = i_st.slot_free;
                o_cmd.clr_nak = i_st.slot_free;
                o_cmd.op      = sra_pkg::OP_SEND;
                o_cmd.kind    = sra_pkg::KIND_NAK;
            end
            sra_pkg::S_TX_ACK: begin
                o_cmd.emit = i_st.slot_free;
                o_cmd.op   = sra_pkg::OP_SEND;
                o_cmd.kind = sra_pkg::KIND_ACK;
            end
            sra_pkg::S_TX_START: begin
                o_cmd.emit = i_st.slot_free;
                o_cmd.op   = sra_pkg::OP_START;
            end
            sra_pkg::S_TX_STOP_ACK: begin
                o_cmd.emit = i_st.slot_free;
                o_cmd.op   = sra_pkg::OP_STOP_ACK;
            end
            sra_pkg::S_DONE: begin
                o_cmd.emit = i_st.slot_free;
                o_cmd.op   = sra_pkg::OP_DONE;
            end
            default: o_cmd = '0;
        endcase
    end
endmodule

// ===== src/sra_dp.sv =====
// Window state, frame buffers and result register of the ARQ endpoint
`timescale 1ns / 1ps
module sra_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sra_pkg::t_cmd               i_cmd,
    output sra_pkg::t_status            o_st,
    input  logic [2:0]                  i_action,
    input  logic [1:0]                  i_rx_kind,
    input  logic [sra_pkg::SEQ_W-1:0]   i_rx_seq,
    input  logic [sra_pkg::SEQ_W-1:0]   i_rx_ack,
    input  logic [sra_pkg::DATA_W-1:0]  i_payload,
    input  logic [sra_pkg::SEQ_W-1:0]   i_expired_seq,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_op,
    output logic [1:0]                  o_tx_kind,
    output logic [sra_pkg::SEQ_W-1:0]   o_tx_seq,
    output logic [sra_pkg::SEQ_W-1:0]   o_tx_ack,
    output logic [sra_pkg::DATA_W-1:0]  o_data_word,
    output logic [sra_pkg::SLOT_W-1:0]  o_timer_slot,
    output logic                        o_upper_enable,
    output logic                        o_last
);
    // latched event
    logic [2:0]                 r_act;
    logic [1:0]                 r_kind;
    logic [sra_pkg::SEQ_W-1:0]  r_seq, r_ack, r_exp_in;
    logic [sra_pkg::DATA_W-1:0] r_word;

    // protocol state
    logic [sra_pkg::SEQ_W-1:0]  r_ack_oldest, r_next_send, r_expected, r_win_top, r_nr;
    logic [sra_pkg::CNT_W-1:0]  r_count, r_guard;
    logic                       r_nak_allowed;
    logic [sra_pkg::BUF_CNT-1:0] r_arrived;
    logic [sra_pkg::DATA_W-1:0] r_out_buf [sra_pkg::BUF_CNT];
    logic [sra_pkg::DATA_W-1:0] r_in_buf  [sra_pkg::BUF_CNT];

    // result register
    logic                       r_valid, r_last, r_en;
    logic [2:0]                 r_op;
    logic [1:0]                 r_tx_kind;
    logic [sra_pkg::SEQ_W-1:0]  r_tx_seq, r_tx_ack;
    logic [sra_pkg::DATA_W-1:0] r_data;
    logic [sra_pkg::SLOT_W-1:0] r_slot;

    logic [sra_pkg::SEQ_W-1:0]  n_want;
    logic                       n_guard_ok, n_full, n_send, n_send_data;

    assign n_want      = r_ack + 3'd1;
    assign n_guard_ok  = r_guard < sra_pkg::CNT_W'(sra_pkg::BUF_CNT);
    assign n_full      = r_count == sra_pkg::CNT_W'(sra_pkg::BUF_CNT);
    assign n_send      = i_cmd.op == sra_pkg::OP_SEND;
    assign n_send_data = n_send && (i_cmd.kind == sra_pkg::KIND_DATA);

    always_comb begin
        o_st.act         = r_act;
        o_st.kind        = r_kind;
        o_st.full        = n_full;
        o_st.nak_allowed = r_nak_allowed;
        o_st.seq_ne_exp  = r_seq != r_expected;
        o_st.store_ok    = sra_pkg::in_window(r_expected, r_seq, r_win_top)
                           && !r_arrived[r_seq[sra_pkg::SLOT_W-1:0]];
        o_st.deliver_ok  = r_arrived[r_expected[sra_pkg::SLOT_W-1:0]] && n_guard_ok;
        o_st.ackloop_ok  = sra_pkg::in_window(r_ack_oldest, r_ack, r_next_send)
                           && (r_count != '0) && n_guard_ok;
        o_st.nak_ok      = sra_pkg::in_window(r_ack_oldest, n_want, r_next_send);
        o_st.slot_free   = !r_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act    <= i_action;
            r_kind   <= i_rx_kind;
            r_seq    <= i_rx_seq;
            r_ack    <= i_rx_ack;
            r_word   <= i_payload;
            r_exp_in <= i_expired_seq;
        end
        if (i_cmd.push) begin
            r_out_buf[r_next_send[sra_pkg::SLOT_W-1:0]] <= r_word;
            r_nr <= r_next_send;
        end
        if (i_cmd.nr_expired) r_nr <= r_exp_in;
        if (i_cmd.nr_want) r_nr <= n_want;
        if (i_cmd.store) r_in_buf[r_seq[sra_pkg::SLOT_W-1:0]] <= r_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_oldest  <= '0;
            r_next_send   <= '0;
            r_expected    <= '0;
            r_win_top     <= sra_pkg::WIN_RESET;
            r_count       <= '0;
            r_guard       <= '0;
            r_nak_allowed <= 1'b1;
            r_arrived     <= '0;
        end else begin
            if (i_cmd.push) begin
                r_count     <= r_count + 3'd1;
                r_next_send <= r_next_send + 3'd1;
            end
            if (i_cmd.clr_nak) r_nak_allowed <= 1'b0;
            if (i_cmd.store) r_arrived[r_seq[sra_pkg::SLOT_W-1:0]] <= 1'b1;
            if (i_cmd.clr_guard) r_guard <= '0;
            if (i_cmd.deliver) begin
                r_nak_allowed <= 1'b1;
                r_arrived[r_expected[sra_pkg::SLOT_W-1:0]] <= 1'b0;
                r_expected <= r_expected + 3'd1;
                r_win_top  <= r_win_top + 3'd1;
                r_guard    <= r_guard + 3'd1;
            end
            if (i_cmd.ack_step) begin
                r_count      <= r_count - 3'd1;
                r_ack_oldest <= r_ack_oldest + 3'd1;
                r_guard      <= r_guard + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_op      <= i_cmd.op;
            r_tx_kind <= n_send ? i_cmd.kind : sra_pkg::KIND_DATA;
            r_tx_seq  <= n_send_data ? r_nr : '0;
            r_tx_ack  <= n_send ? r_expected + sra_pkg::SEQ_MAX : '0;
            if (n_send_data) r_data <= r_out_buf[r_nr[sra_pkg::SLOT_W-1:0]];
            else if (i_cmd.op == sra_pkg::OP_DELIVER)
                r_data <= r_in_buf[r_expected[sra_pkg::SLOT_W-1:0]];
            else r_data <= '0;
            if (i_cmd.op == sra_pkg::OP_START) r_slot <= r_nr[sra_pkg::SLOT_W-1:0];
            else if (i_cmd.op == sra_pkg::OP_STOP) r_slot <= r_ack_oldest[sra_pkg::SLOT_W-1:0];
            else r_slot <= '0;
            r_en      <= (i_cmd.op == sra_pkg::OP_DONE) && !n_full;
            r_last    <= i_cmd.op == sra_pkg::OP_DONE;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_op           = r_op;
    assign o_tx_kind      = r_tx_kind;
    assign o_tx_seq       = r_tx_seq;
    assign o_tx_ack       = r_tx_ack;
    assign o_data_word    = r_data;
    assign o_timer_slot   = r_slot;
    assign o_upper_enable = r_en;
    assign o_last         = r_last;
endmodule
